@@ design/tcw_pkg.sv @@
// tcw_pkg: shared types, constants and helpers for the text console writer.
// Used by every module of the block but tcw_ram; depends on nothing.
package tcw_pkg;

    // Screen geometry
    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

    // Internal widths follow the geometry
    localparam int CUR_COL_W = $clog2(SCREEN_COLUMNS);
    localparam int CUR_ROW_W = $clog2(SCREEN_ROWS);
    localparam int ADDR_W    = $clog2(CELL_COUNT);
    localparam int CELL_W    = 16;

    // Port field widths
    localparam int REQ_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int IN_COL_W   = 7;
    localparam int IN_ROW_W   = 5;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_ADDR_W = 11;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR   = 1'd1;
    localparam logic [ATTR_W-1:0]    ATTR_RESET       = 8'd7;

    // Request kinds on the input stream
    localparam logic [REQ_W-1:0] REQ_PUT_ATTR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUT_DEF  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Classified operations handed from front to back
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
    localparam logic [OP_W-1:0] OP_NEWLINE = 3'd2;
    localparam logic [OP_W-1:0] OP_RETURN  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Store walk bounds
    localparam logic [ADDR_W-1:0] LAST_MOVE  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CELL_W-1:0]    cell_word;  // attribute in the upper byte
        logic [CUR_COL_W-1:0] col;        // saturated target column
        logic [CUR_ROW_W-1:0] row;        // saturated target row
        logic [ADDR_W-1:0]    addr;       // cell address of the target
    } t_cmd;

    typedef struct packed {
        logic [ATTR_W-1:0] default_attr;
        logic [ATTR_W-1:0] clear_attr;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [ATTR_W-1:0]     read_attr;
        logic [CHAR_W-1:0]     read_char;
        logic [OUT_ADDR_W-1:0] cursor_address;
        logic [OUT_ROW_W-1:0]  cursor_row;
        logic [OUT_COL_W-1:0]  cursor_column;
    } t_result;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CUR_ROW_W-1:0] row,
                                                   input logic [CUR_COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

@@ design/tcw_ram.sv @@
// tcw_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/tcw_front.sv @@
// tcw_front: holds the configuration registers and classifies input requests
// into queue commands. Depends on tcw_pkg.
module tcw_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [tcw_pkg::REQ_W-1:0]        i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]       i_cell_attr,
    input  logic [tcw_pkg::IN_COL_W-1:0]     i_column,
    input  logic [tcw_pkg::IN_ROW_W-1:0]     i_row,
    output tcw_pkg::t_cmd                    o_cmd,
    output tcw_pkg::t_cfg                    o_cfg
);

    logic [tcw_pkg::ATTR_W-1:0]    r_default_attr;
    logic [tcw_pkg::ATTR_W-1:0]    r_clear_attr;
    logic [tcw_pkg::CUR_COL_W-1:0] sat_col;
    logic [tcw_pkg::CUR_ROW_W-1:0] sat_row;
    logic [tcw_pkg::ATTR_W-1:0]    put_attr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= tcw_pkg::ATTR_RESET;
            r_clear_attr   <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tcw_pkg::CFG_DEFAULT_ATTR: r_default_attr <= i_cfg_data;
                tcw_pkg::CFG_CLEAR_ATTR:   r_clear_attr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.default_attr = r_default_attr;
    assign o_cfg.clear_attr   = r_clear_attr;

    // saturate targets to the screen
    always_comb begin
        if (int'(i_column) >= tcw_pkg::SCREEN_COLUMNS) begin
            sat_col = tcw_pkg::CUR_COL_W'(tcw_pkg::SCREEN_COLUMNS - 1);
        end else begin
            sat_col = tcw_pkg::CUR_COL_W'(i_column);
        end
        if (int'(i_row) >= tcw_pkg::SCREEN_ROWS) begin
            sat_row = tcw_pkg::CUR_ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
        end else begin
            sat_row = tcw_pkg::CUR_ROW_W'(i_row);
        end
    end

    // classify the request
    always_comb begin
        put_attr        = (i_req_type == tcw_pkg::REQ_PUT_DEF) ? r_default_attr : i_cell_attr;
        o_cmd.cell_word = {put_attr, i_char_code};
        o_cmd.col       = sat_col;
        o_cmd.row       = sat_row;
        o_cmd.addr      = tcw_pkg::cell_addr(sat_row, sat_col);
        case (i_req_type)
            tcw_pkg::REQ_PUT_ATTR, tcw_pkg::REQ_PUT_DEF: begin
                if (i_char_code == tcw_pkg::CH_NEWLINE) begin
                    o_cmd.op = tcw_pkg::OP_NEWLINE;
                end else if (i_char_code == tcw_pkg::CH_RETURN) begin
                    o_cmd.op = tcw_pkg::OP_RETURN;
                end else begin
                    o_cmd.op = tcw_pkg::OP_PUT;
                end
            end
            tcw_pkg::REQ_SET:   o_cmd.op = tcw_pkg::OP_SET;
            tcw_pkg::REQ_CLEAR: o_cmd.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::REQ_READ:  o_cmd.op = tcw_pkg::OP_READ;
            default:            o_cmd.op = tcw_pkg::OP_NONE;
        endcase
    end

endmodule

@@ design/tcw_cmd_fifo.sv @@
// tcw_cmd_fifo: short command queue between the front and the back.
// Depends on tcw_pkg.
module tcw_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcw_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output tcw_pkg::t_cmd      o_head,
    output tcw_pkg::t_q_status o_status
);

    tcw_pkg::t_cmd                   r_mem [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [tcw_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [tcw_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == tcw_pkg::QUEUE_CNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == tcw_pkg::QUEUE_PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + tcw_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == tcw_pkg::QUEUE_PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + tcw_pkg::QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + tcw_pkg::QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - tcw_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

@@ design/tcw_back.sv @@
// tcw_back: executes queued commands on the cell store and the cursor, and
// holds the result register. Depends on tcw_pkg and tcw_ram.
module tcw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_cfg      i_cfg,
    input  tcw_pkg::t_cmd      i_head,
    input  tcw_pkg::t_q_status i_q,
    output logic               o_pop,
    output tcw_pkg::t_result   o_result,
    output logic               o_valid,
    input  logic               i_ready
);

    // sequencer states
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_EXEC   = 3'd1;
    localparam logic [ST_W-1:0] ST_SCR_RD = 3'd2;
    localparam logic [ST_W-1:0] ST_SCR_WR = 3'd3;
    localparam logic [ST_W-1:0] ST_FILL   = 3'd4;
    localparam logic [ST_W-1:0] ST_CLEAR  = 3'd5;
    localparam logic [ST_W-1:0] ST_EMIT   = 3'd6;

    logic [ST_W-1:0]                r_state, n_state;
    tcw_pkg::t_cmd                  r_cmd, n_cmd;
    logic [tcw_pkg::ADDR_W-1:0]     r_idx, n_idx;
    logic [tcw_pkg::CUR_ROW_W-1:0]  r_row, n_row;
    logic [tcw_pkg::CUR_COL_W-1:0]  r_col, n_col;
    logic                           r_out_valid, n_out_valid;
    tcw_pkg::t_result               r_out, n_out;

    logic                           wr_en;
    logic [tcw_pkg::ADDR_W-1:0]     wr_addr;
    logic [tcw_pkg::CELL_W-1:0]     wr_data;
    logic                           rd_en;
    logic [tcw_pkg::ADDR_W-1:0]     rd_addr;
    logic [tcw_pkg::CELL_W-1:0]     rd_data;
    logic                           slot_free;
    logic                           last_col;
    logic                           last_row;
    logic [tcw_pkg::ADDR_W-1:0]     cur_addr;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign slot_free = !r_out_valid || i_ready;
    assign last_col  = (r_col == tcw_pkg::CUR_COL_W'(tcw_pkg::SCREEN_COLUMNS - 1));
    assign last_row  = (r_row == tcw_pkg::CUR_ROW_W'(tcw_pkg::SCREEN_ROWS - 1));
    assign cur_addr  = tcw_pkg::cell_addr(r_row, r_col);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_row       = r_row;
        n_col       = r_col;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = {i_cfg.default_attr, tcw_pkg::CH_SPACE};
        rd_en       = 1'b0;
        rd_addr     = r_idx + tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLUMNS);

        case (r_state)
            ST_IDLE: begin
                if (!i_q.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_EMIT;
                case (r_cmd.op)
                    tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
                        // put writes the cell, then advances like a newline at the edge
                        if (r_cmd.op == tcw_pkg::OP_PUT) begin
                            wr_en   = 1'b1;
                            wr_addr = cur_addr;
                            wr_data = r_cmd.cell_word;
                        end
                        if (r_cmd.op == tcw_pkg::OP_PUT && !last_col) begin
                            n_col = r_col + tcw_pkg::CUR_COL_W'(1);
                        end else begin
                            n_col = '0;
                            if (last_row) begin
                                n_idx   = '0;
                                n_state = ST_SCR_RD;
                            end else begin
                                n_row = r_row + tcw_pkg::CUR_ROW_W'(1);
                            end
                        end
                    end
                    tcw_pkg::OP_RETURN: n_col = '0;
                    tcw_pkg::OP_SET: begin
                        n_col = r_cmd.col;
                        n_row = r_cmd.row;
                    end
                    tcw_pkg::OP_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_idx   = '0;
                        n_state = ST_CLEAR;
                    end
                    tcw_pkg::OP_READ: begin
                        rd_en   = 1'b1;
                        rd_addr = r_cmd.addr;
                    end
                    default: ;
                endcase
            end

            // scroll: copy each cell from one row below
            ST_SCR_RD: begin
                rd_en   = 1'b1;
                n_state = ST_SCR_WR;
            end

            ST_SCR_WR: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (r_idx == tcw_pkg::LAST_MOVE) begin
                    n_idx   = tcw_pkg::FILL_START;
                    n_state = ST_FILL;
                end else begin
                    n_idx   = r_idx + tcw_pkg::ADDR_W'(1);
                    n_state = ST_SCR_RD;
                end
            end

            // blank last row after scroll
            ST_FILL: begin
                wr_en = 1'b1;
                if (r_idx == tcw_pkg::LAST_CELL) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + tcw_pkg::ADDR_W'(1);
                end
            end

            // clear: every cell gets a space in the clear attribute
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = {i_cfg.clear_attr, tcw_pkg::CH_SPACE};
                if (r_idx == tcw_pkg::LAST_CELL) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + tcw_pkg::ADDR_W'(1);
                end
            end

            // once the output slot is free, load the result register and take any queued command straight away
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid          = 1'b1;
                    n_out.cursor_column  = tcw_pkg::OUT_COL_W'(r_col);
                    n_out.cursor_row     = tcw_pkg::OUT_ROW_W'(r_row);
                    n_out.cursor_address = tcw_pkg::OUT_ADDR_W'(cur_addr);
                    if (r_cmd.op == tcw_pkg::OP_READ) begin
                        n_out.read_char = rd_data[tcw_pkg::CHAR_W-1:0];
                        n_out.read_attr = rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                    end else begin
                        n_out.read_char = '0;
                        n_out.read_attr = '0;
                    end
                    if (!i_q.empty) begin
                        o_pop   = 1'b1;
                        n_cmd   = i_head;
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

endmodule

@@ design/text_console_writer_unit.sv @@
// text_console_writer_unit: top level of the text console writer.
// Depends on tcw_pkg, tcw_front, tcw_cmd_fifo, tcw_back (and tcw_ram below it).
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser req_type, tdata fields
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata cursor and read fields
//  cfg       in         i_cfg_wr_en                     i_cfg_index, i_cfg_data
//
// Put, newline, return, set cursor, read and unused requests each pass through an
// execute and an emit state. A scroll copies every cell below the top row up a row,
// with a read and a write state per cell, then blanks the last row; a clear writes
// all CELL_COUNT (2000) cells. Both walk the RAM one cell per step. Reset clears the
// cursor, the queue and the result register; the cell store is not cleared. A stalled
// output holds its result while up to two requests queue.
module text_console_writer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_code[7:0], cell_attr[15:8], column[22:16], row[27:23], zero[31:28]
    input  logic [tcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[2:0]
    input  logic [tcw_pkg::REQ_W-1:0]        s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cursor_column[6:0], cursor_row[11:7], cursor_address[22:12],
    // read_char[30:23], read_attr[38:31], zero[39]
    output logic [tcw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    tcw_pkg::t_cmd      front_cmd;
    tcw_pkg::t_cfg      cfg;
    tcw_pkg::t_cmd      q_head;
    tcw_pkg::t_q_status q_status;
    logic               q_pop;
    tcw_pkg::t_result   result;

    // front: config and classification
    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (s_axis_tuser),
        .i_char_code (s_axis_tdata[7:0]),
        .i_cell_attr (s_axis_tdata[15:8]),
        .i_column    (s_axis_tdata[22:16]),
        .i_row       (s_axis_tdata[27:23]),
        .o_cmd       (front_cmd),
        .o_cfg       (cfg)
    );

    assign s_axis_tready = !q_status.full;

    // queue between front and back
    tcw_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_axis_tvalid),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // back: store, cursor and result register
    tcw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_head   (q_head),
        .i_q      (q_status),
        .o_pop    (q_pop),
        .o_result (result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule

@@ design/tcw_checker.sv @@
// tcw_checker: port-level assertions for text_console_writer_unit, bound in below.
// Depends on tcw_pkg.
module tcw_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [tcw_pkg::OUT_COL_W-1:0]  out_col;
    logic [tcw_pkg::OUT_ROW_W-1:0]  out_row;
    logic [tcw_pkg::OUT_ADDR_W-1:0] out_addr;
    logic [tcw_pkg::OUT_ADDR_W-1:0] exp_addr;

    assign out_col  = m_axis_tdata[6:0];
    assign out_row  = m_axis_tdata[11:7];
    assign out_addr = m_axis_tdata[22:12];
    assign exp_addr = tcw_pkg::OUT_ADDR_W'(tcw_pkg::cell_addr(
                          tcw_pkg::CUR_ROW_W'(out_row), tcw_pkg::CUR_COL_W'(out_col)));

    // result stays valid while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // reported address matches reported cursor
    a_addr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_addr == exp_addr)
        else $error("cursor address does not match cursor position");

    // cursor stays on screen
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(out_col) < tcw_pkg::SCREEN_COLUMNS) &&
                          (int'(out_row) < tcw_pkg::SCREEN_ROWS))
        else $error("cursor outside screen");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
